>>> rtl/mac_presence_table_with_aging_assert.svh
// Assertion macros for the checker file mpt_check.sv.
`ifndef MAC_PRESENCE_TABLE_WITH_AGING_ASSERT_SVH
`define MAC_PRESENCE_TABLE_WITH_AGING_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define MPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mpt_pkg.sv
`default_nettype none

package mpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [11:0] MIN_FRAME = 12'd4;
    localparam logic [7:0]  TTL_RESET = 8'd60;
    localparam logic [15:0] SEEN_MAX  = 16'hFFFF;
    localparam logic [6:0]  ONLINE_MAX = 7'd127;

    typedef struct packed {
        logic        operation;
        logic [47:0] source_mac;
        logic [11:0] frame_length;
    } t_in_word;

    typedef struct packed {
        logic        frame_taken;
        logic        matched;
        logic [5:0]  slot;
        logic [15:0] devices_seen;
        logic [6:0]  online_count;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_drop;
    } t_sts;

    function automatic logic [5:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+5:0] w;
        w = {6'b0, idx};
        return w[5:0];
    endfunction

    function automatic logic [6:0] sat_online(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+6:0] w;
        w = {7'b0, cnt};
        return (w > (CNT_W+7)'(ONLINE_MAX)) ? ONLINE_MAX : w[6:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/mpt_ctrl.sv
`default_nettype none

module mpt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    input  wire mpt_pkg::t_sts i_sts,
    output mpt_pkg::t_cmd     o_cmd
);
    import mpt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_vld;
    logic             out_free;
    logic             last_idx;

    assign out_free    = !r_out_vld || i_out_ready;
    assign last_idx    = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_en  = (r_state == S_SCAN);
        o_cmd.rd_idx = r_idx;
        o_cmd.finish = (r_state == S_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_idx   <= '0;
                        r_state <= i_sts.in_drop ? S_FINISH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (last_idx) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/mpt_dp.sv
`default_nettype none

module mpt_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mpt_pkg::t_cmd     i_cmd,
    output mpt_pkg::t_sts          o_sts,
    input  wire mpt_pkg::t_in_word i_in_word,
    input  wire logic              i_cfg_we,
    input  wire logic [7:0]        i_cfg_wdata,
    output mpt_pkg::t_out_word     o_out_word
);
    import mpt_pkg::*;

    logic [47:0]      mem_addr [TABLE_DEPTH];
    logic [7:0]       mem_ttl  [TABLE_DEPTH];

    logic             r_op;
    logic             r_drop;
    logic [47:0]      r_mac;
    logic [7:0]       r_ttl_reload;
    logic [47:0]      r_addr_q;
    logic [7:0]       r_ttl_q;
    logic             r_stg_vld;
    logic [IDX_W-1:0] r_stg_idx;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] r_online;
    logic             r_found;
    logic [IDX_W-1:0] r_pos;
    logic [CNT_W-1:0] r_acc;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_next;
    logic [15:0]      r_seen;
    t_out_word        r_out;

    logic             n_ok;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      n_seen;
    logic             stg_valid;
    logic [7:0]       ttl_dec;
    logic             tick_wr;
    logic             hit;
    logic             commit;
    logic [IDX_W-1:0] fin_pos;

    assign o_sts.in_drop = !i_in_word.operation && (i_in_word.frame_length < MIN_FRAME);
    assign o_out_word    = r_out;

    assign stg_valid = r_valid[r_stg_idx];
    assign ttl_dec   = (r_ttl_q != 8'd0) ? r_ttl_q - 8'd1 : 8'd0;
    assign tick_wr   = r_stg_vld && r_op && stg_valid;
    assign hit       = r_stg_vld && !r_op && stg_valid && !r_found && (r_addr_q == r_mac);
    assign n_ok      = !r_op && !r_drop;
    assign commit    = i_cmd.finish && n_ok;
    assign fin_pos   = r_found ? r_pos : r_next;

    always_comb begin
        n_count = r_count;
        n_seen  = r_seen;
        if (i_cmd.finish && r_op) begin
            n_count = r_acc;
        end else if (commit) begin
            if (!(r_valid[fin_pos] && r_online[fin_pos])) begin
                n_count = r_count + CNT_W'(1);
            end
            if (!r_found && (r_seen != SEEN_MAX)) begin
                n_seen = r_seen + 16'd1;
            end
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_addr_q <= mem_addr[i_cmd.rd_idx];
            r_ttl_q  <= mem_ttl[i_cmd.rd_idx];
        end
        if (commit && !r_found) begin
            mem_addr[fin_pos] <= r_mac;
        end
        if (tick_wr) begin
            mem_ttl[r_stg_idx] <= ttl_dec;
        end else if (commit) begin
            mem_ttl[fin_pos] <= r_ttl_reload;
        end
    end

    // latched item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_in_word.operation;
            r_mac  <= i_in_word.source_mac;
            r_drop <= o_sts.in_drop;
        end
        r_stg_idx <= i_cmd.rd_idx;
        if (hit) begin
            r_pos <= r_stg_idx;
        end
        if (i_cmd.finish) begin
            r_out.frame_taken  <= n_ok;
            r_out.matched      <= n_ok && r_found;
            r_out.slot         <= n_ok ? to_slot(fin_pos) : 6'd0;
            r_out.devices_seen <= n_seen;
            r_out.online_count <= sat_online(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_reload <= TTL_RESET;
            r_stg_vld    <= 1'b0;
            r_valid      <= '0;
            r_online     <= '0;
            r_found      <= 1'b0;
            r_acc        <= '0;
            r_count      <= '0;
            r_next       <= '0;
            r_seen       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ttl_reload <= i_cfg_wdata;
            end
            r_stg_vld <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_found <= 1'b0;
                r_acc   <= '0;
            end
            if (hit) begin
                r_found <= 1'b1;
            end
            if (tick_wr) begin
                if (ttl_dec == 8'd0) begin
                    r_online[r_stg_idx] <= 1'b0;
                end else if (r_online[r_stg_idx]) begin
                    r_acc <= r_acc + CNT_W'(1);
                end
            end
            if (commit) begin
                r_valid[fin_pos]  <= 1'b1;
                r_online[fin_pos] <= 1'b1;
                if (!r_found) begin
                    r_next <= (r_next == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_next + IDX_W'(1);
                end
            end
            r_count <= n_count;
            r_seen  <= n_seen;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mac_presence_table_with_aging.sv
// Channel | Direction | Handshake                    | Word
// in      | input     | i_in_valid / o_in_ready      | i_in_word  (t_in_word)
// out     | output    | o_out_valid / i_out_ready    | o_out_word (t_out_word)
// cfg     | input     | i_cfg_we, no wait            | i_cfg_wdata (ttl_reload)
//
// A frame or tick is accepted, then walks serially over the address and TTL
// memories one slot at a time, then drains the read stage and commits.
// A dropped frame goes from accept straight to commit.
// Synchronous active-low reset empties the table and loads ttl_reload with 60.
// A finished word waits in the output register; the next item is taken
// meanwhile, and only the commit step holds while that register is full.
`default_nettype none

module mac_presence_table_with_aging (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire mpt_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mpt_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_we,
    input  wire logic [7:0]         i_cfg_wdata
);
    import mpt_pkg::*;

    // command and status between sequencer and table datapath
    t_cmd cmd;
    t_sts sts;

    // Sequencer: accept a word, walk every slot, drain, commit; a dropped frame goes straight to commit.
    mpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: address and TTL memories, valid and online marks,
    // lookup compare, TTL countdown, counters and the result register.
    mpt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

>>> rtl/mpt_check.sv
`default_nettype none

`include "mac_presence_table_with_aging_assert.svh"

module mpt_check (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire mpt_pkg::t_out_word o_out_word
);
    import mpt_pkg::*;

    // a stalled result word holds
    `MPT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word), "result word changed under stall")

    // one item at a time: busy right after an accept
    `MPT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "input taken twice in a row")

    // ticks and dropped frames report no match and slot zero
    `MPT_ASSERT(a_untaken_fields, i_clk, i_rst_n, o_out_valid && !o_out_word.frame_taken |-> !o_out_word.matched && (o_out_word.slot == 6'd0), "untaken word reports a match or slot")

    // never more online than slots
    `MPT_ASSERT(a_online_bound, i_clk, i_rst_n, o_out_valid |-> (o_out_word.online_count <= 7'(TABLE_DEPTH)), "online count above table depth")

endmodule

bind mac_presence_table_with_aging mpt_check u_check (.*);

`default_nettype wire
